// ===== src/sddm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddm_pkg
// Shared types and constants for the stereo delay with dry/wet mix.
// ----------------------------------------------------------------------------
package sddm_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int LEN_W     = 13;
	localparam int MIX_W     = 16;
	localparam int CFG_W     = 16;
	localparam int IDX_W     = 1;
	localparam int PROD_W    = SAMPLE_W + MIX_W + 1;
	localparam int SUM_W     = PROD_W + 1;
	localparam int FRAC_W    = 15;

	localparam int OUT_DEPTH = 4;
	localparam int PTR_W     = $clog2(OUT_DEPTH);
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
	localparam int OCC_W     = CNT_W + 1;

	localparam logic [IDX_W-1:0] REG_DELAY_LENGTH = 1'b0;
	localparam logic [IDX_W-1:0] REG_MIX_GAIN     = 1'b1;

	localparam logic [LEN_W-1:0] LEN_RESET = 13'd5000;
	localparam logic [MIX_W-1:0] MIX_RESET = 16'd0;
	localparam logic [MIX_W-1:0] MIX_ONE   = 16'h8000;

	typedef struct packed {
		logic accept;
		logic bypass;
		logic stored;
	} lane_ctl_t;

endpackage

// ===== src/sddm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sddm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/sddm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddm_lane
// One channel: circular delay store and the dry/wet blend pipeline.
// ----------------------------------------------------------------------------
module sddm_lane #(
	parameter int DEPTH = 8192
) (
	input  logic                                   clk,
	input  sddm_pkg::lane_ctl_t                    ctl,
	input  logic [$clog2(DEPTH)-1:0]               wr_addr,
	input  logic [$clog2(DEPTH)-1:0]               rd_addr,
	input  logic signed [sddm_pkg::SAMPLE_W-1:0]   sample,
	input  logic [sddm_pkg::MIX_W-1:0]             dry_w,
	input  logic [sddm_pkg::MIX_W-1:0]             wet_w,
	output logic signed [sddm_pkg::SAMPLE_W-1:0]   result
);

	logic [sddm_pkg::SAMPLE_W-1:0]        rd_data;
	logic signed [sddm_pkg::SAMPLE_W-1:0] dry_s1;
	logic                                 bypass_s1;
	logic                                 stored_s1;
	logic signed [sddm_pkg::SAMPLE_W-1:0] wet;
	logic signed [sddm_pkg::PROD_W-1:0]   prod_dry;
	logic signed [sddm_pkg::PROD_W-1:0]   prod_wet;
	logic signed [sddm_pkg::PROD_W-1:0]   prod_dry_s2;
	logic signed [sddm_pkg::PROD_W-1:0]   prod_wet_s2;
	logic signed [sddm_pkg::SUM_W-1:0]    sum;
	logic signed [sddm_pkg::SUM_W-1:0]    rnd;

	sddm_ram #(
		.WIDTH(sddm_pkg::SAMPLE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ctl.accept),
		.waddr(wr_addr),
		.wdata(sample),
		.re   (ctl.accept),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			dry_s1    <= sample;
			bypass_s1 <= ctl.bypass;
			stored_s1 <= ctl.stored;
		end
	end

	// entries past the fill mark are not taken from the store; they read as zero
	always_comb begin
		if (bypass_s1) begin
			wet = dry_s1;
		end else if (stored_s1) begin
			wet = $signed(rd_data);
		end else begin
			wet = '0;
		end
	end

	assign prod_dry = dry_s1 * $signed({1'b0, dry_w});
	assign prod_wet = wet * $signed({1'b0, wet_w});

	always_ff @(posedge clk) begin
		prod_dry_s2 <= prod_dry;
		prod_wet_s2 <= prod_wet;
	end

	// divide by 2^15 truncating toward zero
	assign sum = sddm_pkg::SUM_W'(prod_dry_s2) + sddm_pkg::SUM_W'(prod_wet_s2);
	assign rnd = sum[sddm_pkg::SUM_W-1]
		? sum + sddm_pkg::SUM_W'((1 << sddm_pkg::FRAC_W) - 1) : sum;
	assign result = rnd[sddm_pkg::FRAC_W +: sddm_pkg::SAMPLE_W];

endmodule

// ===== src/sddm_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddm_merge
// Joins the two lane results into one frame and queues it for the output.
// ----------------------------------------------------------------------------
module sddm_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic signed [sddm_pkg::SAMPLE_W-1:0] left,
	input  logic signed [sddm_pkg::SAMPLE_W-1:0] right,
	output logic [sddm_pkg::CNT_W-1:0]           count,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [2*sddm_pkg::SAMPLE_W-1:0]      m_axis_tdata
);

	logic [2*sddm_pkg::SAMPLE_W-1:0] fifo_q [sddm_pkg::OUT_DEPTH];
	logic [sddm_pkg::PTR_W-1:0]      wr_ptr_q;
	logic [sddm_pkg::PTR_W-1:0]      rd_ptr_q;
	logic [sddm_pkg::CNT_W-1:0]      count_q;
	logic                            pop;

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = fifo_q[rd_ptr_q];
	assign count         = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= {right, left};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/stereo_delay_dry_wet_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_delay_dry_wet_mix
// Stereo circular delay line with a Q1.15 dry/wet blend per channel.
// ----------------------------------------------------------------------------
// channel   dir  handshake                     payload
// s_axis    in   tvalid / tready               left_sample, right_sample
// m_axis    out  tvalid / tready               left_out, right_out
// wr_*      in   wr_en, no wait                delay_length, mix_gain
//
// one frame per cycle sustained while m_axis_tready stays high; a frame passes the
// stage-1 and stage-2 registers and the output queue before m_axis_tvalid rises
// store write, store read and position update all happen in the accept cycle
// stores need no clearing pass: a fill mark makes unwritten entries read zero
// a 4-entry output queue absorbs stalls; s_axis_tready drops once queue plus
// the two pipeline stages hold 4 frames
// ----------------------------------------------------------------------------
module stereo_delay_dry_wet_mix #(
	parameter int DELAY_DEPTH = 8192
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [2*sddm_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // left_sample, right_sample
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [2*sddm_pkg::SAMPLE_W-1:0]  m_axis_tdata,  // left_out, right_out
	input  logic                             wr_en,
	input  logic [sddm_pkg::IDX_W-1:0]       wr_index,
	input  logic [sddm_pkg::CFG_W-1:0]       wr_data
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int CW = ($clog2(DELAY_DEPTH + 1) > sddm_pkg::LEN_W)
		? $clog2(DELAY_DEPTH + 1) : sddm_pkg::LEN_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);

	logic [sddm_pkg::LEN_W-1:0]           delay_length_q;
	logic [sddm_pkg::MIX_W-1:0]           mix_gain_q;
	logic [AW-1:0]                        wp_q;
	logic [CW-1:0]                        fill_q;
	logic                                 vld_s1;
	logic                                 vld_s2;

	logic                                 accept;
	logic [CW-1:0]                        len_ext;
	logic [CW-1:0]                        len_eff;
	logic [CW-1:0]                        next_w;
	logic [AW-1:0]                        next_pos;
	logic [CW-1:0]                        fill_new;
	sddm_pkg::lane_ctl_t                  ctl;
	logic [sddm_pkg::MIX_W-1:0]           wet_w;
	logic [sddm_pkg::MIX_W-1:0]           dry_w;
	logic signed [sddm_pkg::SAMPLE_W-1:0] left_res;
	logic signed [sddm_pkg::SAMPLE_W-1:0] right_res;
	logic [sddm_pkg::CNT_W-1:0]           q_count;
	logic [sddm_pkg::OCC_W-1:0]           occ;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q <= sddm_pkg::LEN_RESET;
			mix_gain_q     <= sddm_pkg::MIX_RESET;
		end else if (wr_en) begin
			case (wr_index)
				sddm_pkg::REG_DELAY_LENGTH: delay_length_q <= wr_data[sddm_pkg::LEN_W-1:0];
				sddm_pkg::REG_MIX_GAIN:     mix_gain_q     <= wr_data;
				default: ;
			endcase
		end
	end

	assign wet_w = (mix_gain_q > sddm_pkg::MIX_ONE) ? sddm_pkg::MIX_ONE : mix_gain_q;
	assign dry_w = sddm_pkg::MIX_ONE - wet_w;

	// write position and fill mark
	assign len_ext = CW'(delay_length_q);
	always_comb begin
		if (len_ext == '0) begin
			len_eff = CW'(1);
		end else if (len_ext > DEPTH_C) begin
			len_eff = DEPTH_C;
		end else begin
			len_eff = len_ext;
		end
	end

	assign next_w   = CW'(wp_q) + CW'(1);
	assign next_pos = (next_w >= len_eff) ? '0 : next_w[AW-1:0];
	assign fill_new = (CW'(wp_q) >= fill_q) ? next_w : fill_q;

	assign occ           = sddm_pkg::OCC_W'(q_count) + sddm_pkg::OCC_W'(vld_s1)
		+ sddm_pkg::OCC_W'(vld_s2);
	assign s_axis_tready = (occ < sddm_pkg::OCC_W'(sddm_pkg::OUT_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign ctl.accept = accept;
	assign ctl.bypass = (next_pos == wp_q);
	assign ctl.stored = (CW'(next_pos) < fill_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			if (accept) begin
				wp_q   <= next_pos;
				fill_q <= fill_new;
			end
		end
	end

	sddm_lane #(
		.DEPTH(DELAY_DEPTH)
	) u_lane_left (
		.clk    (clk),
		.ctl    (ctl),
		.wr_addr(wp_q),
		.rd_addr(next_pos),
		.sample ($signed(s_axis_tdata[sddm_pkg::SAMPLE_W-1:0])),
		.dry_w  (dry_w),
		.wet_w  (wet_w),
		.result (left_res)
	);

	sddm_lane #(
		.DEPTH(DELAY_DEPTH)
	) u_lane_right (
		.clk    (clk),
		.ctl    (ctl),
		.wr_addr(wp_q),
		.rd_addr(next_pos),
		.sample ($signed(s_axis_tdata[2*sddm_pkg::SAMPLE_W-1:sddm_pkg::SAMPLE_W])),
		.dry_w  (dry_w),
		.wet_w  (wet_w),
		.result (right_res)
	);

	sddm_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (vld_s2),
		.left         (left_res),
		.right        (right_res),
		.count        (q_count),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

// ===== src/sddm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sddm_checker
// Port-level checks on frame accounting and latency, bound to the top level.
// ----------------------------------------------------------------------------
module sddm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [2*sddm_pkg::SAMPLE_W-1:0] m_axis_tdata
);

	logic                         in_req;
	logic                         out_req;
	logic [sddm_pkg::OCC_W-1:0]   pending_q;

	assign in_req  = s_axis_tvalid && s_axis_tready;
	assign out_req = m_axis_tvalid && m_axis_tready;

	// frames accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_req && !out_req) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_req && !in_req) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (pending_q != '0))
		else $error("output request with no frame pending");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= sddm_pkg::OCC_W'(sddm_pkg::OUT_DEPTH))
		else $error("more frames pending than the output queue holds");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == '0) |-> s_axis_tready)
		else $error("input stalled with nothing pending");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_req && (pending_q == '0)) |=> ##2 m_axis_tvalid)
		else $error("result not shown three cycles after request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled output request changed");

endmodule

bind stereo_delay_dry_wet_mix sddm_checker u_sddm_checker (.*);
